[hdl/wfr_pkg.sv]
// Package for the WebSocket frame receiver: parse phases, opcodes,
// result kinds and field widths. No dependencies.
package wfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = 3;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 17'h10000;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_STOP = 3'd5
  } phase_t;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [KIND_W-1:0] KIND_TEXT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STOP = 2'd3;

  localparam logic CAUSE_CLOSE = 1'b0;
  localparam logic CAUSE_LEN   = 1'b1;

  localparam logic [BYTE_W-1:0] PONG_BYTE0 = 8'h8A;
  localparam logic [6:0]        LEN7_EXT16 = 7'd126;
  localparam logic [6:0]        LEN7_EXT64 = 7'd127;

endpackage

[hdl/websocket_frame_receiver_unit.sv]
// WebSocket frame receiver, top level: header parse, length check, unmask,
// pong generation and a four-entry result buffer. Depends on wfr_pkg.
//
// Bytes from the connection enter on s_axis one per beat. Each accepted byte
// is parsed in the cycle it arrives (header, 16/64-bit extended length,
// masking key, payload) and the results it causes, none to four of them,
// are written at once into a small result buffer that m_axis drains one
// beat per cycle while m_axis_tready is high; tlast marks the final result
// of a byte. After a byte that causes no result or one result the next byte
// can follow straight away, provided a waiting result is taken in that same
// cycle. A byte that causes more than one result holds off the next byte
// until the buffer is down to its last entry: that occurs on the end of a
// text frame (payload byte plus completion, two beats) and on a pong header
// (up to four beats). The length cap is to be written through cfg_wr_en/
// cfg_wr_data only while the block is idle; the block does not enforce this.
// Once the session stops (close frame or over-length frame) every further
// byte is swallowed until reset.
module websocket_frame_receiver_unit
  import wfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,     // max_payload_length
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,    // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,    // [7:0] data_byte, [8] stop_cause, rest zero
  output logic [KIND_W-1:0] m_axis_tuser,    // [1:0] kind
  output logic              m_axis_tlast     // last result of this input byte
);

  // Parser state
  phase_t             phase, phase_next;
  logic               fin, fin_next;
  logic [3:0]         opcode, opcode_next;
  logic               masked, masked_next;
  logic [LEN_W-1:0]   len, len_next;
  logic               len_ovf, len_ovf_next;   // bits beyond the 17 held are set
  logic [3:0]         ext_left, ext_left_next;
  logic [31:0]        key, key_next;
  logic [LEN_W-1:0]   idx, idx_next;
  logic [LEN_W-1:0]   max_len;

  // Result buffer
  logic [KIND_W-1:0]  buf_kind  [MAX_RES];
  logic [BYTE_W-1:0]  buf_data  [MAX_RES];
  logic               buf_cause [MAX_RES];
  logic [CNT_W-1:0]   buf_cnt;
  logic [1:0]         rd_ptr;

  // Results of the byte now on the input
  logic [KIND_W-1:0]  res_kind  [MAX_RES];
  logic [BYTE_W-1:0]  res_data  [MAX_RES];
  logic               res_cause [MAX_RES];
  logic [CNT_W-1:0]   res_n;

  logic               in_acc, out_acc;
  logic [BYTE_W-1:0]  b, d;
  logic               do_len_done, do_begin, do_end;

  assign b       = s_axis_tdata;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Next byte may enter once at most the last buffered beat is outstanding
  // and leaves this cycle.
  assign s_axis_tready = (buf_cnt == '0) || ((buf_cnt == CNT_W'(1)) && m_axis_tready);

  // Parse one byte; results are appended in order at res_n.
  always_comb begin
    phase_next    = phase;
    fin_next      = fin;
    opcode_next   = opcode;
    masked_next   = masked;
    len_next      = len;
    len_ovf_next  = len_ovf;
    ext_left_next = ext_left;
    key_next      = key;
    idx_next      = idx;
    do_len_done   = 1'b0;
    do_begin      = 1'b0;
    do_end        = 1'b0;
    res_n         = '0;
    d             = b;
    for (int i = 0; i < MAX_RES; i++) begin
      res_kind[i]  = KIND_TEXT;
      res_data[i]  = '0;
      res_cause[i] = CAUSE_CLOSE;
    end

    case (phase)
      PH_HDR0: begin
        fin_next    = b[7];
        opcode_next = b[3:0];
        phase_next  = PH_HDR1;
      end
      PH_HDR1: begin
        masked_next  = b[7];
        len_ovf_next = 1'b0;
        if (b[6:0] == LEN7_EXT16) begin
          len_next      = '0;
          ext_left_next = 4'd2;
          phase_next    = PH_EXT;
        end else if (b[6:0] == LEN7_EXT64) begin
          len_next      = '0;
          ext_left_next = 4'd8;
          phase_next    = PH_EXT;
        end else begin
          len_next    = LEN_W'(b[6:0]);
          do_len_done = 1'b1;
        end
      end
      PH_EXT: begin
        len_ovf_next  = len_ovf || (len[LEN_W-1:LEN_W-8] != '0);
        len_next      = {len[LEN_W-9:0], b};
        ext_left_next = ext_left - 4'd1;
        do_len_done   = (ext_left == 4'd1);
      end
      PH_KEY: begin
        key_next      = {key[23:0], b};
        ext_left_next = ext_left - 4'd1;
        do_begin      = (ext_left == 4'd1);
      end
      PH_DATA: begin
        if (masked) begin
          case (idx[1:0])
            2'd0:    d = b ^ key[31:24];
            2'd1:    d = b ^ key[23:16];
            2'd2:    d = b ^ key[15:8];
            default: d = b ^ key[7:0];
          endcase
        end
        if (opcode == OP_PING) begin
          res_kind[res_n[1:0]] = KIND_TX;
          res_data[res_n[1:0]] = d;
          res_n                = res_n + CNT_W'(1);
        end else if (opcode == OP_TEXT && fin) begin
          res_kind[res_n[1:0]] = KIND_TEXT;
          res_data[res_n[1:0]] = d;
          res_n                = res_n + CNT_W'(1);
        end
        idx_next = idx + LEN_W'(1);
        // length is within the cap here, so no wrap of the index
        do_end   = (idx_next >= len);
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase

    // Length complete: cap check, then key or payload
    if (do_len_done) begin
      key_next = '0;
      if (len_ovf_next || (len_next > max_len)) begin
        phase_next            = PH_STOP;
        res_kind[res_n[1:0]]  = KIND_STOP;
        res_cause[res_n[1:0]] = CAUSE_LEN;
        res_n                 = res_n + CNT_W'(1);
      end else if (masked_next) begin
        ext_left_next = 4'd4;
        phase_next    = PH_KEY;
      end else begin
        do_begin = 1'b1;
      end
    end

    // Header complete: pong header for a ping, then payload or frame end
    if (do_begin) begin
      idx_next = '0;
      if (opcode == OP_PING) begin
        res_kind[res_n[1:0]] = KIND_TX;
        res_data[res_n[1:0]] = PONG_BYTE0;
        res_n                = res_n + CNT_W'(1);
        if (len_next < LEN_W'(LEN7_EXT16)) begin
          res_kind[res_n[1:0]] = KIND_TX;
          res_data[res_n[1:0]] = len_next[7:0];
          res_n                = res_n + CNT_W'(1);
        end else begin
          res_kind[res_n[1:0]] = KIND_TX;
          res_data[res_n[1:0]] = BYTE_W'(LEN7_EXT16);
          res_n                = res_n + CNT_W'(1);
          res_kind[res_n[1:0]] = KIND_TX;
          res_data[res_n[1:0]] = len_next[15:8];
          res_n                = res_n + CNT_W'(1);
          res_kind[res_n[1:0]] = KIND_TX;
          res_data[res_n[1:0]] = len_next[7:0];
          res_n                = res_n + CNT_W'(1);
        end
      end
      if (len_next == '0) begin
        do_end = 1'b1;
      end else begin
        phase_next = PH_DATA;
      end
    end

    // Frame end: close stops the session, final text reports completion
    if (do_end) begin
      if (opcode == OP_CLOSE) begin
        phase_next            = PH_STOP;
        res_kind[res_n[1:0]]  = KIND_STOP;
        res_cause[res_n[1:0]] = CAUSE_CLOSE;
        res_n                 = res_n + CNT_W'(1);
      end else begin
        if (opcode == OP_TEXT && fin) begin
          res_kind[res_n[1:0]] = KIND_DONE;
          res_n                = res_n + CNT_W'(1);
        end
        phase_next = PH_HDR0;
      end
    end
  end

  // Parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HDR0;
      fin      <= 1'b0;
      opcode   <= '0;
      masked   <= 1'b0;
      len      <= '0;
      len_ovf  <= 1'b0;
      ext_left <= '0;
      key      <= '0;
      idx      <= '0;
    end else if (in_acc) begin
      phase    <= phase_next;
      fin      <= fin_next;
      opcode   <= opcode_next;
      masked   <= masked_next;
      len      <= len_next;
      len_ovf  <= len_ovf_next;
      ext_left <= ext_left_next;
      key      <= key_next;
      idx      <= idx_next;
    end
  end

  // Length cap
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  // Result buffer: loaded whole by an accepted byte, drained one beat a cycle while m_axis_tready is high
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
      rd_ptr  <= '0;
    end else if (in_acc) begin
      buf_cnt <= res_n;
      rd_ptr  <= '0;
    end else if (out_acc) begin
      buf_cnt <= buf_cnt - CNT_W'(1);
      rd_ptr  <= rd_ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_kind[i]  <= res_kind[i];
        buf_data[i]  <= res_data[i];
        buf_cause[i] <= res_cause[i];
      end
    end
  end

  assign m_axis_tvalid = (buf_cnt != '0);
  assign m_axis_tuser  = buf_kind[rd_ptr];
  assign m_axis_tdata  = {7'b0, buf_cause[rd_ptr], buf_data[rd_ptr]};
  assign m_axis_tlast  = (buf_cnt == CNT_W'(1));

  // A stopped session stays stopped until reset.
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STOP) |=> (phase == PH_STOP))
    else $error("session left the stopped phase");

  // A stop report is always the final result of its byte.
  a_stop_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_STOP)) |-> m_axis_tlast)
    else $error("stop result not marked last");

  // While reading payload the index stays below a checked, in-range length.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (!len_ovf && (idx < len)))
    else $error("payload index beyond frame length");

  // Buffer never holds more than one byte's worth of results.
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (buf_cnt <= CNT_W'(MAX_RES)))
    else $error("result buffer overfilled");

endmodule

[tb/tb.sv]
// Self-checking bench for websocket_frame_receiver_unit: streams frames into
// the receiver and checks every result beat against a frame parser of its own
// or typed-in results. Depends on wfr_pkg and the receiver RTL.
module tb;
  import wfr_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic              cause;
    logic              last;
  } beat_t;

  // one byte offered to the receiver, optionally with its results typed in
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    bit                typed;
    logic [2:0]        cnt;
    beat_t [0:3]       r;
  } rx_row_t;

  localparam int ENC7  = 0;
  localparam int ENC16 = 1;
  localparam int ENC64 = 2;
  localparam beat_t NOB = '0;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic [KIND_W-1:0] m_axis_tuser;
  logic             m_axis_tlast;

  websocket_frame_receiver_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // parser state, mirrors the receiver
  phase_t           ph_m    = PH_HDR0;
  logic             fin_m   = 1'b0;
  logic [3:0]       op_m    = '0;
  logic             mask_m  = 1'b0;
  logic [63:0]      len_m   = '0;
  logic [3:0]       ext_m   = '0;
  logic [31:0]      key_m   = '0;
  logic [16:0]      idx_m   = '0;
  logic [LEN_W-1:0] cap_m   = MAX_LEN_RESET;

  beat_t   step_beats[$];
  beat_t   pending_beats[$];
  rx_row_t cur_row = '0;

  int    errors = 0;
  int    bytes_in = 0;
  int    beats_out = 0;
  int    bytes_sent = 0;
  int    frames_sent = 0;
  int    src_idle = 0;
  int    snk_stall = 0;
  int    stall_left = 0;
  int    hold_asked = 0;
  int    hold_seen = 0;
  string stop_note = "nothing";

  // ---------------- frame parser ----------------
  function automatic void add_result(logic [KIND_W-1:0] k, logic [7:0] d, logic c);
    beat_t x;
    x = '{kind: k, data: d, cause: c, last: 1'b0};
    if (step_beats.size() < MAX_RES)
      step_beats = {step_beats, x};
  endfunction

  function automatic void halt_session(logic c);
    ph_m = PH_STOP;
    add_result(KIND_STOP, 8'h00, c);
  endfunction

  function automatic void frame_done();
    if (op_m == OP_CLOSE) begin
      halt_session(CAUSE_CLOSE);
      return;
    end
    if (op_m == OP_TEXT && fin_m)
      add_result(KIND_DONE, 8'h00, 1'b0);
    ph_m = PH_HDR0;
  endfunction

  function automatic void open_payload();
    idx_m = '0;
    if (op_m == OP_PING) begin
      add_result(KIND_TX, PONG_BYTE0, 1'b0);
      if (len_m < 64'(LEN7_EXT16)) begin
        add_result(KIND_TX, len_m[7:0], 1'b0);
      end else begin
        add_result(KIND_TX, 8'(LEN7_EXT16), 1'b0);
        add_result(KIND_TX, len_m[15:8], 1'b0);
        add_result(KIND_TX, len_m[7:0], 1'b0);
      end
    end
    if (len_m == '0)
      frame_done();
    else
      ph_m = PH_DATA;
  endfunction

  function automatic void length_known();
    if (len_m > {47'b0, cap_m}) begin
      halt_session(CAUSE_LEN);
      return;
    end
    key_m = '0;
    if (mask_m) begin
      ext_m = 4'd4;
      ph_m  = PH_KEY;
    end else begin
      open_payload();
    end
  endfunction

  function automatic void parse_rx_byte(logic [7:0] b);
    logic [7:0] d;
    case (ph_m)
      PH_HDR0: begin
        fin_m = b[7];
        op_m  = b[3:0];
        ph_m  = PH_HDR1;
      end
      PH_HDR1: begin
        mask_m = b[7];
        len_m  = '0;
        if (b[6:0] == LEN7_EXT16) begin
          ext_m = 4'd2;
          ph_m  = PH_EXT;
        end else if (b[6:0] == LEN7_EXT64) begin
          ext_m = 4'd8;
          ph_m  = PH_EXT;
        end else begin
          len_m = {57'b0, b[6:0]};
          length_known();
        end
      end
      PH_EXT: begin
        len_m = {len_m[55:0], b};
        ext_m = ext_m - 4'd1;
        if (ext_m == '0) length_known();
      end
      PH_KEY: begin
        key_m = {key_m[23:0], b};
        ext_m = ext_m - 4'd1;
        if (ext_m == '0) open_payload();
      end
      PH_DATA: begin
        d = b;
        if (mask_m) d = d ^ key_m[31 - 8 * idx_m[1:0] -: 8];
        if (op_m == OP_PING)
          add_result(KIND_TX, d, 1'b0);
        else if (op_m == OP_TEXT && fin_m)
          add_result(KIND_TEXT, d, 1'b0);
        idx_m = idx_m + 17'd1;
        if ({47'b0, idx_m} >= len_m) frame_done();
      end
      default: ph_m = PH_STOP;
    endcase
  endfunction

  // ---------------- scoreboard ----------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    beat_t want;
    beat_t nb;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      step_beats.delete();
      parse_rx_byte(s_axis_tdata);
      bytes_in++;
      if (cur_row.typed) begin
        for (int i = 0; i < int'(cur_row.cnt); i++)
          pending_beats = {pending_beats, cur_row.r[i]};
      end else begin
        foreach (step_beats[i]) begin
          nb = step_beats[i];
          nb.last = (i == step_beats.size() - 1);
          pending_beats = {pending_beats, nb};
        end
      end
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, expected none, got kind %0h data %0h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("data_byte", want.data, m_axis_tdata[7:0]);
        check_field("stop_cause", want.cause, m_axis_tdata[8]);
        check_field("last", want.last, m_axis_tlast);
        check_field("tdata pad", 0, m_axis_tdata[15:9]);
      end
    end
  end

  // sink: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_asked != hold_seen) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 300;
      hold_seen     <= hold_asked;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall);
    end
  end

  // ---------------- stimulus ----------------
  function automatic beat_t bt(logic [1:0] k, logic [7:0] d, logic c, logic l);
    return '{kind: k, data: d, cause: c, last: l};
  endfunction

  function automatic rx_row_t row(logic [7:0] b, bit typed, int n, beat_t r0 = NOB,
                                  beat_t r1 = NOB);
    rx_row_t x;
    x       = '0;
    x.b     = b;
    x.typed = typed;
    x.cnt   = 3'(n);
    x.r[0]  = r0;
    x.r[1]  = r1;
    return x;
  endfunction

  task automatic offer(rx_row_t r);
    if (src_idle != 0 && $urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.b;
    cur_row       <= r;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [3:0] op, bit fin, bit masked, logic [63:0] len, int enc);
    logic [31:0] key;
    offer(row({fin, 3'($urandom), op}, 0, 0));
    case (enc)
      ENC7:  offer(row({masked, len[6:0]}, 0, 0));
      ENC16: begin
        offer(row({masked, LEN7_EXT16}, 0, 0));
        offer(row(len[15:8], 0, 0));
        offer(row(len[7:0], 0, 0));
      end
      default: begin
        offer(row({masked, LEN7_EXT64}, 0, 0));
        for (int i = 7; i >= 0; i--) offer(row(len[8*i +: 8], 0, 0));
      end
    endcase
    frames_sent++;
    if (len > {47'b0, cap_m}) return;  // session is over, no key or payload follows
    key = $urandom;
    if (masked)
      for (int i = 3; i >= 0; i--) offer(row(key[8*i +: 8], 0, 0));
    for (longint i = 0; i < longint'(len); i++) offer(row(8'($urandom), 0, 0));
  endtask

  // well-formed short frame with random content, never a close, never over the cap
  task automatic random_frame();
    int unsigned r;
    logic [3:0]  op;
    bit          fin;
    int unsigned len;
    int          enc;
    r = $urandom_range(99);
    if (r < 40)      op = OP_TEXT;
    else if (r < 65) op = OP_PING;
    else             op = 4'($urandom);
    if (op == OP_CLOSE) op = OP_TEXT;
    fin = (op == OP_TEXT) ? ($urandom_range(99) < 85) : 1'($urandom);
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(16);
    else        len = $urandom_range(17, 48);
    if (len > cap_m) len = $urandom_range(cap_m);
    r = $urandom_range(99);
    enc = (r < 70) ? ENC7 : ((r < 85) ? ENC16 : ENC64);
    send_frame(op, fin, $urandom_range(99) < 70, 64'(len), enc);
  endtask

  task automatic run_frames(int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) random_frame();
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cap(logic [LEN_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cap_m = v;
  endtask

  // the one stop the run can afford, picked at random
  task automatic end_session();
    logic [63:0] len;
    case ($urandom_range(2))
      0: begin
        len = 64'($urandom_range(1, (cap_m < 16) ? cap_m : 16));
        send_frame(OP_CLOSE, 1'b1, 1'($urandom), len, ENC7);
        stop_note = "a close frame with payload";
      end
      1: begin
        send_frame(OP_CLOSE, 1'($urandom), 1'b0, 64'd0, ENC7);
        stop_note = "an empty close frame";
      end
      default: begin
        if ($urandom_range(1)) begin
          len = {47'b0, cap_m} + 64'd1 + 64'($urandom_range(60));
          send_frame(4'($urandom), 1'b1, 1'b1, len, ENC16);
        end else begin
          len = {$urandom | 32'h1, $urandom};
          send_frame(4'($urandom), 1'b1, 1'b1, len, ENC64);
        end
        stop_note = "a frame over the length cap";
      end
    endcase
  endtask

  initial begin : main
    rx_row_t dir_tab[22];

    // final text "hi", unmasked
    dir_tab[0]  = row(8'h81, 1, 0);
    dir_tab[1]  = row(8'h02, 1, 0);
    dir_tab[2]  = row(8'h68, 1, 1, bt(KIND_TEXT, 8'h68, 1'b0, 1'b1));
    dir_tab[3]  = row(8'h69, 1, 2, bt(KIND_TEXT, 8'h69, 1'b0, 1'b0),
                      bt(KIND_DONE, 8'h00, 1'b0, 1'b1));
    // masked ping of three bytes, pong header on the last key byte
    dir_tab[4]  = row(8'h89, 1, 0);
    dir_tab[5]  = row(8'h83, 1, 0);
    dir_tab[6]  = row(8'hFF, 0, 0);
    dir_tab[7]  = row(8'h00, 0, 0);
    dir_tab[8]  = row(8'hAA, 0, 0);
    dir_tab[9]  = row(8'h55, 1, 2, bt(KIND_TX, PONG_BYTE0, 1'b0, 1'b0),
                      bt(KIND_TX, 8'h03, 1'b0, 1'b1));
    dir_tab[10] = row(8'h00, 0, 0);
    dir_tab[11] = row(8'hFF, 0, 0);
    dir_tab[12] = row(8'h5A, 0, 0);
    // empty ping through the 16-bit length form
    dir_tab[13] = row(8'h89, 1, 0);
    dir_tab[14] = row({1'b0, LEN7_EXT16}, 1, 0);
    dir_tab[15] = row(8'h00, 1, 0);
    dir_tab[16] = row(8'h00, 1, 2, bt(KIND_TX, PONG_BYTE0, 1'b0, 1'b0),
                      bt(KIND_TX, 8'h00, 1'b0, 1'b1));
    // text fragment without FIN: payload dropped
    dir_tab[17] = row(8'h01, 1, 0);
    dir_tab[18] = row(8'h01, 1, 0);
    dir_tab[19] = row(8'hAB, 1, 0);
    // empty pong, reserved bits all set
    dir_tab[20] = row({1'b1, 3'b111, 4'hA}, 1, 0);
    dir_tab[21] = row(8'h00, 1, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) offer(dir_tab[i]);

    run_frames(15);
    wait_drained();

    // zero cap: only empty frames get through
    src_idle = 85;
    set_cap('0);
    run_frames(10);
    wait_drained();

    src_idle  = 0;
    snk_stall = 85;
    set_cap(LEN_W'($urandom_range(130, 400)));
    run_frames(15);
    wait_drained();

    // full cap; sink held off while a ping with a four-beat pong header
    // streams in and fills the buffer
    src_idle  = 34;
    snk_stall = 34;
    set_cap(MAX_LEN_RESET);
    hold_asked++;
    send_frame(OP_PING, 1'b1, 1'b1, 64'd126, ENC16);
    run_frames(10);
    wait_drained();

    src_idle  = 0;
    snk_stall = 0;
    set_cap(LEN_W'($urandom_range(1, 200)));
    run_frames(10);
    end_session();
    for (int i = 0; i < 8; i++) offer(row(8'($urandom), 0, 0));  // swallowed
    s_axis_tvalid <= 1'b0;

    do @(posedge clk); while (pending_beats.size() != 0);
    repeat (16) @(posedge clk);

    $display("Run: %0d bytes in %0d frames, %0d result beats, caps 0 to 65536.",
             bytes_in, frames_sent, beats_out);
    $display("Session closed by %s.", stop_note);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Timed out with %0d result beats outstanding.", pending_beats.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
